// ----- hw/rtl/srs_pkg.sv -----
// Package for the sorted range first/last search block.
// Holds the default sizes, field widths, action codes and the sequencer state type.
// It depends on nothing else.
`default_nettype none

package srs_pkg;

  // Default store geometry.
  localparam int STORE_DEPTH_DEF = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths of the request and result ports.
  localparam int INDEX_BITS   = 10;
  localparam int COUNT_BITS   = 11;
  localparam int OUT_IDX_BITS = 11;

  // Search bounds run from -1 up to the largest count, so they carry one extra bit.
  localparam int POS_BITS = COUNT_BITS + 1;

  // Action codes of a request.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Index reported when the key is absent.
  localparam logic signed [OUT_IDX_BITS-1:0] NO_INDEX = '1;

  // Search passes.
  localparam logic PASS_FIRST = 1'b0;
  localparam logic PASS_LAST  = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SEARCH,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/srs_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the value store of the sorted range search block; depends on nothing else.
`default_nettype none

module srs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_range_first_last_search_core.sv -----
// Top level of the sorted range first/last search block.
// Depends on srs_pkg for sizes, codes and the state type, and on srs_ram for the store.
//
// Usage:
// The store holds signed values in non-decreasing order. Software fills it with
// write requests (action = write, entry_index, entry_value) and sets the number of
// entries in use through the configuration channel (cfg_valid/cfg_ready, entry_count).
// A query request (action = query, search_key) returns one result with the lowest
// and highest index holding the key and a found flag; both indices are -1 when the
// key is absent. A write request returns nothing and leaves the core idle.
// A query runs two binary searches on one shared compare unit. Each pass starts in
// a load state that issues its first read, then makes at most floor(log2(n)) + 1
// probes for n entries in use. No new request is taken until the query has reached
// its final state and handed its result to the output register. An empty range
// skips both searches and goes straight to the final state.
// Results sit in an output register; a new request is taken while a result waits,
// and a finished query waits in its final state until the output register is free.
// Reset clears the sequencer, the output valid flag and the stored entry count. The
// store is not cleared; an entry must be written before a query can probe it.
`default_nettype none

module sorted_range_first_last_search_core #(
  parameter int STORE_DEPTH = srs_pkg::STORE_DEPTH_DEF,
  parameter int VALUE_WIDTH = srs_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  // Configuration channel.
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic        [srs_pkg::COUNT_BITS-1:0]   entry_count,
  // Request channel.
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic                                    action,
  input  wire logic        [srs_pkg::INDEX_BITS-1:0]   entry_index,
  input  wire logic signed [VALUE_WIDTH-1:0]           entry_value,
  input  wire logic signed [VALUE_WIDTH-1:0]           search_key,
  // Result channel.
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic signed      [srs_pkg::OUT_IDX_BITS-1:0] first_index,
  output logic signed      [srs_pkg::OUT_IDX_BITS-1:0] last_index,
  output logic                                         found
);

  import srs_pkg::*;

  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Configuration register.
  logic [COUNT_BITS-1:0] count_reg;

  // Sequencer and search registers.
  state_t                           state, state_next;
  logic                             pass, pass_next;
  logic [POS_BITS-1:0]              lo, lo_next;
  logic [POS_BITS-1:0]              hi, hi_next;
  logic [POS_BITS-1:0]              mid, mid_next;
  logic signed [VALUE_WIDTH-1:0]    key, key_next;
  logic signed [OUT_IDX_BITS-1:0]   ans, ans_next;
  logic signed [OUT_IDX_BITS-1:0]   first, first_next;
  logic signed [OUT_IDX_BITS-1:0]   last, last_next;
  logic                             hit, hit_next;
  logic                             res_valid_next;
  logic                             res_load;

  // Store interface.
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  // Clamped count of entries in use and the initial upper bound.
  logic [31:0]         count_wide;
  logic [POS_BITS-1:0] count_pos;
  logic [POS_BITS-1:0] hi_init;

  // Shared compare unit and bound update.
  logic                probe_eq;
  logic                probe_gt;
  logic [POS_BITS-1:0] step_lo;
  logic [POS_BITS-1:0] step_hi;
  logic [POS_BITS-1:0] step_mid;
  logic signed [OUT_IDX_BITS-1:0] step_ans;
  logic                step_hit;
  logic                step_more;
  logic [POS_BITS-1:0] load_mid;

  logic in_take;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_take   = in_valid && in_ready;

  // Configuration write.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      count_reg <= entry_count;
    end
  end

  // A count above the store depth searches the whole store.
  assign count_wide = (32'(count_reg) > 32'(STORE_DEPTH)) ? 32'(STORE_DEPTH)
                                                          : 32'(count_reg);
  assign count_pos  = POS_BITS'(count_wide);
  assign hi_init    = count_pos - POS_BITS'(1);

  // Write requests beyond the store are dropped.
  assign ram_we    = in_take && (action == ACT_WRITE)
                     && (32'(entry_index) < 32'(STORE_DEPTH));
  assign ram_waddr = ADDR_W'(entry_index);

  srs_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (entry_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Midpoint of the current bounds, used for the first probe of a pass.
  assign load_mid = lo + ((hi - lo) >> 1);

  // Compare the probed entry with the key and narrow the bounds.
  always_comb begin
    probe_eq = ($signed(ram_rdata) == key);
    probe_gt = ($signed(ram_rdata) > key);
    step_lo  = lo;
    step_hi  = hi;
    step_ans = ans;
    step_hit = hit;
    if (probe_eq) begin
      step_ans = $signed(OUT_IDX_BITS'(mid));
      if (pass == PASS_FIRST) begin
        step_hit = 1'b1;
        step_hi  = mid - POS_BITS'(1);
      end else begin
        step_lo  = mid + POS_BITS'(1);
      end
    end else if (probe_gt) begin
      step_hi = mid - POS_BITS'(1);
    end else begin
      step_lo = mid + POS_BITS'(1);
    end
    step_more = ($signed(step_lo) <= $signed(step_hi));
    step_mid  = step_lo + ((step_hi - step_lo) >> 1);
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Search datapath registers.
  always_ff @(posedge clk) begin
    pass  <= pass_next;
    lo    <= lo_next;
    hi    <= hi_next;
    mid   <= mid_next;
    key   <= key_next;
    ans   <= ans_next;
    first <= first_next;
    last  <= last_next;
    hit   <= hit_next;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      first_index <= first;
      last_index  <= last;
      found       <= hit;
    end
  end

  // Next state, bound updates and read address.
  always_comb begin
    state_next     = state;
    pass_next      = pass;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    key_next       = key;
    ans_next       = ans;
    first_next     = first;
    last_next      = last;
    hit_next       = hit;
    ram_raddr      = ADDR_W'(mid);
    res_load       = 1'b0;
    res_valid_next = out_valid && !out_ready;

    unique case (state)
      ST_IDLE: begin
        if (in_take && (action == ACT_QUERY)) begin
          key_next  = search_key;
          pass_next = PASS_FIRST;
          lo_next   = '0;
          hi_next   = hi_init;
          ans_next  = NO_INDEX;
          hit_next  = 1'b0;
          if (count_pos == '0) begin
            first_next = NO_INDEX;
            last_next  = NO_INDEX;
            state_next = ST_DONE;
          end else begin
            state_next = ST_LOAD;
          end
        end
      end

      ST_LOAD: begin
        // Issue the first probe of a pass.
        ram_raddr  = ADDR_W'(load_mid);
        mid_next   = load_mid;
        state_next = ST_SEARCH;
      end

      ST_SEARCH: begin
        lo_next  = step_lo;
        hi_next  = step_hi;
        ans_next = step_ans;
        hit_next = step_hit;
        if (step_more) begin
          ram_raddr = ADDR_W'(step_mid);
          mid_next  = step_mid;
        end else if (pass == PASS_FIRST) begin
          // First pass done; restart the bounds for the last occurrence.
          first_next = step_ans;
          pass_next  = PASS_LAST;
          lo_next    = '0;
          hi_next    = hi_init;
          ans_next   = NO_INDEX;
          state_next = ST_LOAD;
        end else begin
          last_next  = step_ans;
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid || out_ready) begin
          res_load       = 1'b1;
          res_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- tb/search_result_checker.sv -----
// Checker for the sorted range first/last search core: watches the three channels,
// keeps its own copy of the store and entry count, predicts every query and compares.
// Depends on srs_pkg for the field widths and the action codes.
`timescale 1ns / 1ps

module search_result_checker (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  input  logic                                    cfg_ready,
  input  logic        [srs_pkg::COUNT_BITS-1:0]   entry_count,
  input  logic                                    in_valid,
  input  logic                                    in_ready,
  input  logic                                    action,
  input  logic        [srs_pkg::INDEX_BITS-1:0]   entry_index,
  input  logic signed [31:0]                      entry_value,
  input  logic signed [31:0]                      search_key,
  input  logic                                    out_valid,
  input  logic                                    out_ready,
  input  logic signed [srs_pkg::OUT_IDX_BITS-1:0] first_index,
  input  logic signed [srs_pkg::OUT_IDX_BITS-1:0] last_index,
  input  logic                                    found,
  output int                                      fail_count,
  output int                                      pending,
  output int                                      results_checked
);

  import srs_pkg::*;

  typedef struct packed {
    logic signed [OUT_IDX_BITS-1:0] first_idx;
    logic signed [OUT_IDX_BITS-1:0] last_idx;
    logic                           hit;
  } key_bounds_t;

  logic signed [31:0]    store_copy [STORE_DEPTH_DEF];
  logic [COUNT_BITS-1:0] active_count;
  key_bounds_t           expected_bounds_q [$];
  int                    mismatches;
  int                    checked;

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    mismatches      = 0;
    checked         = 0;
    active_count    = '0;
  end

  // One binary search over entries [0, n-1]; returns the lowest or highest
  // index holding the key, or -1 when no probe matched.
  function automatic int bound_search(input logic signed [31:0] key, input int n,
                                      input bit want_last);
    int lo;
    int hi;
    int mid;
    int ans;
    lo  = 0;
    hi  = n - 1;
    ans = -1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (store_copy[mid] == key) begin
        ans = mid;
        if (want_last) lo = mid + 1;
        else hi = mid - 1;
      end else if (store_copy[mid] > key) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return ans;
  endfunction

  // Track the channels at each edge; results are handled before new requests so
  // that an unexpected result is never paired with a query taken in the same cycle.
  always @(posedge clk) begin
    key_bounds_t want;
    int          n;
    int          lo_hit;
    int          hi_hit;
    if (rst) begin
      expected_bounds_q.delete();
      active_count = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bounds_q.size() == 0) begin
          $error("result arrived with no query outstanding: first_index %0d last_index %0d",
                 first_index, last_index);
          mismatches++;
        end else begin
          want = expected_bounds_q.pop_front();
          checked++;
          if (first_index !== want.first_idx) begin
            $error("first_index: expected %0d, got %0d", want.first_idx, first_index);
            mismatches++;
          end
          if (last_index !== want.last_idx) begin
            $error("last_index: expected %0d, got %0d", want.last_idx, last_index);
            mismatches++;
          end
          if (found !== want.hit) begin
            $error("found: expected %0b, got %0b", want.hit, found);
            mismatches++;
          end
        end
      end

      if (cfg_valid && cfg_ready) active_count = entry_count;

      if (in_valid && in_ready) begin
        if (action == ACT_WRITE) begin
          store_copy[entry_index] = entry_value;
        end else begin
          // Counts above the store depth search the whole store.
          n = (active_count > STORE_DEPTH_DEF) ? STORE_DEPTH_DEF : int'(active_count);
          lo_hit = bound_search(search_key, n, PASS_FIRST);
          hi_hit = bound_search(search_key, n, PASS_LAST);
          want.first_idx = OUT_IDX_BITS'(lo_hit);
          want.last_idx  = OUT_IDX_BITS'(hi_hit);
          want.hit       = (lo_hit >= 0);
          expected_bounds_q.push_back(want);
        end
      end
    end
    fail_count      <= mismatches;
    pending         <= expected_bounds_q.size();
    results_checked <= checked;
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the sorted range first/last search core: clock, reset, stimulus,
// ready stalls, a watchdog and the verdict.
// Depends on srs_pkg, the core and the search_result_checker module.
`timescale 1ns / 1ps

module tb;
  import srs_pkg::*;

  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEM_TARGET    = 1200;

  localparam logic signed [31:0] KEY_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX  = 32'sh7fff_ffff;
  localparam longint             SPAN_MIN = -64'sd2147483648;
  localparam longint             SPAN_MAX = 64'sd2147483647;

  logic                           clk         = 1'b0;
  logic                           rst         = 1'b1;
  logic                           cfg_valid   = 1'b0;
  logic                           cfg_ready;
  logic        [COUNT_BITS-1:0]   entry_count = '0;
  logic                           in_valid    = 1'b0;
  logic                           in_ready;
  logic                           action      = ACT_WRITE;
  logic        [INDEX_BITS-1:0]   entry_index = '0;
  logic signed [31:0]             entry_value = '0;
  logic signed [31:0]             search_key  = '0;
  logic                           out_valid;
  logic                           out_ready   = 1'b0;
  logic signed [OUT_IDX_BITS-1:0] first_index;
  logic signed [OUT_IDX_BITS-1:0] last_index;
  logic                           found;

  int fail_count;
  int pending;
  int results_checked;

  // Stimulus-side view of the store, used only to pick keys that hit.
  logic signed [31:0] mirror [STORE_DEPTH_DEF];
  int  live_count = 0;
  bit  steady = 1'b0;
  bit  stall_enable = 1'b1;
  int  stall_left = 0;
  int  quiet_cycles = 0;
  int  n_writes = 0;
  int  n_queries = 0;
  int  n_phases = 0;

  sorted_range_first_last_search_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .entry_count (entry_count),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .search_key  (search_key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .first_index (first_index),
    .last_index  (last_index),
    .found       (found)
  );

  search_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .entry_count     (entry_count),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .entry_index     (entry_index),
    .entry_value     (entry_value),
    .search_key      (search_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .first_index     (first_index),
    .last_index      (last_index),
    .found           (found),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  always #5 clk = ~clk;

  // Result-side back-pressure: mostly short stalls, now and then a long one.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_enable && $urandom_range(0, 99) < 25) begin
      out_ready  <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: ends the run if no channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[sorted_range_first_last_search_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Idle gap before a request: usually none or short, occasionally long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one request and hold it until taken. Valid stays high into the
  // next request when no gap follows.
  task automatic send_req(input logic act, input logic [INDEX_BITS-1:0] idx,
                          input logic signed [31:0] val, input logic signed [31:0] key);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    entry_index <= idx;
    entry_value <= val;
    search_key  <= key;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_entry(input int idx, input logic signed [31:0] val);
    send_req(ACT_WRITE, INDEX_BITS'(idx), val, $urandom);
    mirror[idx] = val;
    n_writes++;
  endtask

  task automatic ask(input logic signed [31:0] key);
    send_req(ACT_QUERY, INDEX_BITS'($urandom), $urandom, key);
    n_queries++;
  endtask

  // Wait until every query has returned and the core has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Change the number of entries in use; only done with the core idle.
  task automatic set_count(input int c);
    settle();
    cfg_valid   <= 1'b1;
    entry_count <= COUNT_BITS'(c);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    live_count = (c > STORE_DEPTH_DEF) ? STORE_DEPTH_DEF : c;
    n_phases++;
  endtask

  // Fill [0, c-1] in non-decreasing order, either packed with duplicates or
  // spread over the whole signed range.
  task automatic fill_sorted(input int c);
    longint v;
    longint step_max;
    if ($urandom_range(0, 1) == 1) begin
      v        = longint'($signed($urandom));
      step_max = 2;
    end else begin
      v        = SPAN_MIN + $urandom_range(0, 1000);
      step_max = 64'd4294967295 / ((c > 0) ? c : 1);
    end
    for (int i = 0; i < c; i++) begin
      write_entry(i, 32'(v));
      v = v + $urandom_range(0, 32'(step_max));
      if (v > SPAN_MAX) v = SPAN_MAX;
    end
  endtask

  task automatic fill_unsorted(input int c);
    for (int i = 0; i < c; i++) write_entry(i, $urandom);
  endtask

  // Keys mostly hit stored values or sit just beside them.
  function automatic logic signed [31:0] pick_key();
    int r;
    logic signed [31:0] k;
    r = $urandom_range(0, 99);
    if (live_count == 0 || r >= 85) return $urandom;
    k = mirror[$urandom_range(0, live_count - 1)];
    if (r < 55) return k;
    if (r < 70) return k + 1;
    if (r < 80) return k - 1;
    return r[0] ? KEY_MIN : KEY_MAX;
  endfunction

  // Queries on the current contents with some stray writes mixed in.
  task automatic query_burst(input int nq);
    for (int i = 0; i < nq; i++) begin
      if ($urandom_range(0, 9) == 0) write_entry($urandom_range(0, STORE_DEPTH_DEF - 1), $urandom);
      else ask(pick_key());
    end
  endtask

  initial begin
    int c;
    int r;
    int nq;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Count zero straight out of reset: nothing is probed.
    ask(32'sd0);
    ask(KEY_MAX);

    // Small sorted store with duplicates and both extremes of the value range.
    write_entry(0, KEY_MIN);
    write_entry(1, -32'sd5);
    write_entry(2, -32'sd5);
    write_entry(3, 32'sd0);
    write_entry(4, 32'sd7);
    write_entry(5, 32'sd7);
    write_entry(6, 32'sd7);
    write_entry(7, KEY_MAX);
    set_count(8);
    ask(KEY_MIN);
    ask(KEY_MAX);
    ask(-32'sd5);
    ask(32'sd7);
    ask(32'sd0);
    ask(32'sd3);
    ask(KEY_MIN + 32'sd1);
    ask(KEY_MAX - 32'sd1);

    // Single entry, then back to an empty range.
    set_count(1);
    ask(KEY_MIN);
    ask(32'sd0);
    set_count(0);
    ask(32'sd7);

    // Whole store in use, then a count beyond the store depth.
    set_count(STORE_DEPTH_DEF);
    fill_sorted(STORE_DEPTH_DEF);
    query_burst(30);
    set_count((1 << COUNT_BITS) - 1);
    query_burst(15);

    // Random phases over prefixes of the filled store; small ranges are
    // sometimes refilled, packed, spread or unsorted.
    while (n_writes + n_queries < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 8) c = 0;
      else if (r < 70) c = $urandom_range(1, 16);
      else if (r < 92) c = $urandom_range(17, 100);
      else c = $urandom_range(101, STORE_DEPTH_DEF);
      steady = ($urandom_range(0, 4) == 0);
      stall_enable <= ($urandom_range(0, 4) != 0);
      set_count(c);
      if (c <= 16 && $urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 3) == 0) fill_unsorted(c);
        else fill_sorted(c);
      end
      nq = $urandom_range(8, 20);
      query_burst(nq);
    end

    settle();
    $display("Ran %0d writes and %0d queries over %0d entry-count settings,", n_writes,
             n_queries, n_phases);
    $display("with empty, single, full and over-depth ranges; %0d results checked.",
             results_checked);
    if (fail_count == 0) begin
      $display("[sorted_range_first_last_search_core] OK");
    end else begin
      $display("[sorted_range_first_last_search_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/srs_pkg.sv
hw/rtl/srs_ram.sv
hw/rtl/sorted_range_first_last_search_core.sv
tb/search_result_checker.sv
tb/tb.sv
